// ===== rtl/lcdr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCD refresh controller package
// Shared sizes, opcodes, bus write types and the constant tables of the
// panel: initialisation commands, their waits and the Cyrillic code map.
// ----------------------------------------------------------------------------
package lcdr_pkg;

    localparam int CELLS      = 80;
    localparam int LINE_CELLS = 20;
    localparam int CELL_W     = $clog2(CELLS);

    localparam int INIT_STEPS = 7;
    localparam int STEP_W     = 3;

    // opcode codes of an input word
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // DDRAM line address commands
    localparam logic [7:0] LINE_ADDR_0 = 8'h80;
    localparam logic [7:0] LINE_ADDR_1 = 8'hC0;
    localparam logic [7:0] LINE_ADDR_2 = 8'h80 | 8'(LINE_CELLS);
    localparam logic [7:0] LINE_ADDR_3 = 8'hC0 | 8'(LINE_CELLS);

    localparam logic [7:0] CYR_FIRST = 8'd192;

    localparam logic [7:0] INIT_CMD [INIT_STEPS] = '{
        8'h30, 8'h30, 8'h30, 8'h38, 8'h0C, 8'h01, 8'h02
    };
    localparam logic [7:0] INIT_WAIT [INIT_STEPS] = '{
        8'd63, 8'd2, 8'd3, 8'd1, 8'd1, 8'd32, 8'd1
    };

    localparam logic [7:0] CYR_ROM [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    // buffer write request
    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] idx;
        logic [7:0]        code;
        logic              conv;
    } lcdr_wr_t;

    // one bus write towards the panel
    typedef struct packed {
        logic       register_select;
        logic [7:0] bus_byte;
        logic [7:0] next_delay;
    } lcdr_res_t;

endpackage
`default_nettype wire

// ===== rtl/lcdr_screen_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Screen buffer
// Character memory with per-cell valid bits, code conversion on write and a
// registered read port that forwards a write to the address being read.
// ----------------------------------------------------------------------------
module lcdr_screen_buf
    import lcdr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lcdr_wr_t          wr,
    input  wire logic [CELL_W-1:0] rd_addr,
    output logic [7:0]             rd_data
);

    logic [7:0]       mem [CELLS];
    logic [CELLS-1:0] valid_reg;
    logic [7:0]       rd_mem_reg;
    logic             rd_valid_reg;
    logic             hit_reg;
    logic [7:0]       hit_data_reg;
    logic [7:0]       code_conv;

    always_comb
    begin
        code_conv = wr.code;
        if (wr.conv && (wr.code >= CYR_FIRST))
        begin
            code_conv = CYR_ROM[wr.code[5:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= code_conv;
        end
        rd_mem_reg   <= mem[rd_addr];
        hit_data_reg <= code_conv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            // forward a write that lands on the cell being fetched
            hit_reg      <= wr.en && (wr.idx == rd_addr);
        end
    end

    assign rd_data = hit_reg      ? hit_data_reg :
                     rd_valid_reg ? rd_mem_reg   : 8'd0;

endmodule
`default_nettype wire

// ===== rtl/lcdr_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Refresh sequencer
// Wait counter, mode and cursor: runs the init commands, then streams the
// buffer with line address commands ahead of each display line.
// ----------------------------------------------------------------------------
module lcdr_sequencer
    import lcdr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [1:0]        op,
    input  wire logic [7:0]        rd_data,
    output logic                   emit,
    output lcdr_res_t              res,
    output logic [CELL_W-1:0]      rd_addr
);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_LINE = 2'd1,
        MODE_DATA = 2'd2,
        MODE_INIT = 2'd3
    } mode_t;

    mode_t             mode_reg,   mode_next;
    logic [CELL_W-1:0] cursor_reg, cursor_next;
    logic [7:0]        pend_reg,   pend_next;
    logic [7:0]        wait_reg,   wait_next;
    logic [7:0]        wait_dec;
    logic [CELL_W-1:0] cell_next;
    logic [7:0]        cell8;
    logic [STEP_W-1:0] step;

    always_comb
    begin
        mode_next   = mode_reg;
        cursor_next = cursor_reg;
        pend_next   = pend_reg;
        wait_next   = wait_reg;
        emit        = 1'b0;
        res         = '0;
        wait_dec    = (wait_reg != 8'd0) ? (wait_reg - 8'd1) : 8'd0;
        step        = cursor_reg[STEP_W-1:0];
        cell_next   = (cursor_reg == CELL_W'(CELLS - 1)) ? '0 : (cursor_reg + 1'b1);
        cell8       = 8'(cell_next);

        unique case (op)
            OP_TICK:
            begin
                wait_next = wait_dec;
                if (wait_dec == 8'd0)
                begin
                    unique case (mode_reg)
                        MODE_INIT:
                        begin
                            if (cursor_reg < CELL_W'(INIT_STEPS))
                            begin
                                emit        = 1'b1;
                                res         = '{1'b0, INIT_CMD[step], INIT_WAIT[step]};
                                wait_next   = INIT_WAIT[step];
                                cursor_next = cursor_reg + 1'b1;
                            end
                            else
                            begin
                                // sequence done: start streaming after one tick
                                mode_next   = MODE_DATA;
                                cursor_next = '0;
                                wait_next   = 8'd1;
                            end
                        end
                        MODE_LINE:
                        begin
                            emit      = 1'b1;
                            res       = '{1'b0, pend_reg, 8'd1};
                            wait_next = 8'd1;
                            mode_next = MODE_DATA;
                        end
                        MODE_DATA:
                        begin
                            emit        = 1'b1;
                            res         = '{1'b1, rd_data, 8'd1};
                            wait_next   = 8'd1;
                            cursor_next = cell_next;
                            if (cell8 == 8'd0)
                            begin
                                pend_next = LINE_ADDR_0;
                                mode_next = MODE_LINE;
                            end
                            else if (cell8 == 8'(LINE_CELLS))
                            begin
                                pend_next = LINE_ADDR_1;
                                mode_next = MODE_LINE;
                            end
                            else if (cell8 == 8'(2 * LINE_CELLS))
                            begin
                                pend_next = LINE_ADDR_2;
                                mode_next = MODE_LINE;
                            end
                            else if (cell8 == 8'(3 * LINE_CELLS))
                            begin
                                pend_next = LINE_ADDR_3;
                                mode_next = MODE_LINE;
                            end
                        end
                        MODE_IDLE:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            OP_START:
            begin
                cursor_next = '0;
                mode_next   = MODE_INIT;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // fetch the cell that the cursor will point at next
    assign rd_addr = fire ? cursor_next : cursor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            cursor_reg <= '0;
            pend_reg   <= 8'd0;
            wait_reg   <= 8'd0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            cursor_reg <= cursor_next;
            pend_reg   <= pend_next;
            wait_reg   <= wait_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/char_lcd_refresh_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD refresh controller
// 4x20 panel refresh: screen buffer writes, init sequence and buffer streaming.
// ----------------------------------------------------------------------------
// One input word is taken every clock cycle unless the block stalls. A word
// is held in the input register, and its bus write, if any, is registered in
// the output register when the word proceeds, then shows on the master side.
// The block only stalls the slave side when the input register holds a tick
// that produces a bus write while the previous bus write is still waiting to
// be taken. The screen buffer is an on-chip memory read ahead at the cursor
// through a registered port; its reset to zeros is done by per-cell valid bits,
// so there is no clearing pass and words are accepted straight after reset.
module char_lcd_refresh_controller
    import lcdr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // cell_index[6:0], char_code[14:7], zero pad
    input  wire logic [2:0]  s_tuser,   // opcode[1:0], convert_flag[2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // bus_byte[7:0], next_delay[15:8]
    output logic             m_tuser    // register_select
);

    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [6:0]  in_idx_reg;
    logic [7:0]  in_code_reg;
    logic        in_conv_reg;
    logic        out_valid_reg;
    lcdr_res_t   out_res_reg;

    logic              fire;
    logic              emit;
    lcdr_res_t         res;
    lcdr_wr_t          wr;
    logic [CELL_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // proceed unless this word makes a bus write and the output is still held
    assign fire     = in_valid_reg && (!emit || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    assign wr.en   = fire && (in_op_reg == OP_WRITE) && ({1'b0, in_idx_reg} < 8'(CELLS));
    assign wr.idx  = in_idx_reg[CELL_W-1:0];
    assign wr.code = in_code_reg;
    assign wr.conv = in_conv_reg;

    lcdr_screen_buf u_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lcdr_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .op      (in_op_reg),
        .rd_data (rd_data),
        .emit    (emit),
        .res     (res),
        .rd_addr (rd_addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser[1:0];
            in_conv_reg <= s_tuser[2];
            in_idx_reg  <= s_tdata[6:0];
            in_code_reg <= s_tdata[14:7];
        end
        if (fire && emit)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.register_select;
    assign m_tdata  = {out_res_reg.next_delay, out_res_reg.bus_byte};

endmodule
`default_nettype wire
